// ===== hw/rtl/lcgs_pkg.sv =====
`default_nettype none

package lcgs_pkg;

   localparam int SPAN_BITS  = 12;
   localparam int FRAC_BITS  = 16;
   localparam int CHAN_BITS  = 8;
   localparam int ACC_BITS   = FRAC_BITS + 10;
   localparam int DIV_BITS   = FRAC_BITS + CHAN_BITS;
   localparam int CNT_BITS   = $clog2(DIV_BITS);
   localparam int NUM_LANES  = 3;
   localparam int COLOR_BITS = 32;
   localparam int PIXEL_BITS = NUM_LANES * CHAN_BITS;
   localparam int DELTA_BITS = 13;
   localparam int SPAN_MAX   = (1 << SPAN_BITS) - 1;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_STEP = 1'b1
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic div_shift;
      logic div_last;
   } lane_ctrl_type;

   typedef logic [NUM_LANES-1:0][CHAN_BITS-1:0] chan_vec_type;

   // absolute extent, clipped to the span range
   function automatic logic [SPAN_BITS-1:0] span_of(input logic signed [DELTA_BITS-1:0] d);
      logic [DELTA_BITS-1:0] mag;
      mag = unsigned'(d);
      if (d[DELTA_BITS-1]) begin
         mag = ~mag + 1'b1;
      end
      if (32'(mag) > SPAN_MAX) begin
         span_of = SPAN_BITS'(SPAN_MAX);
      end else begin
         span_of = SPAN_BITS'(mag);
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcgs_if.sv =====
`default_nettype none

interface lcgs_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    mode;
   logic [lcgs_pkg::COLOR_BITS-1:0]         start_color;
   logic [lcgs_pkg::COLOR_BITS-1:0]         end_color;
   logic signed [lcgs_pkg::DELTA_BITS-1:0]  delta_x;
   logic signed [lcgs_pkg::DELTA_BITS-1:0]  delta_y;

   modport source (output valid, mode, start_color, end_color, delta_x, delta_y,
                   input ready);
   modport sink (input valid, mode, start_color, end_color, delta_x, delta_y,
                 output ready);
endinterface

interface lcgs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lcgs_pkg::PIXEL_BITS-1:0] pixel_color;

   modport source (output valid, pixel_color, input ready);
   modport sink (input valid, pixel_color, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcgs_lane.sv =====
`default_nettype none

module lcgs_lane (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lcgs_pkg::lane_ctrl_type            ctrl,
   input  wire logic [lcgs_pkg::CHAN_BITS-1:0]     start_chan,
   input  wire logic [lcgs_pkg::CHAN_BITS-1:0]     end_chan,
   input  wire logic [lcgs_pkg::SPAN_BITS-1:0]     span,
   output logic      [lcgs_pkg::CHAN_BITS-1:0]     chan_out
);

   localparam int AB = lcgs_pkg::ACC_BITS;
   localparam int FB = lcgs_pkg::FRAC_BITS;
   localparam int DB = lcgs_pkg::DIV_BITS;
   localparam int SB = lcgs_pkg::SPAN_BITS;
   localparam int CB = lcgs_pkg::CHAN_BITS;

   logic signed [AB-1:0] acc_ff, acc_in;
   logic signed [AB-1:0] inc_ff, inc_in;
   logic [DB-1:0]        quo_ff, quo_in;
   logic [SB-1:0]        rem_ff, rem_in;
   logic                 neg_ff, neg_in;

   logic [SB:0]          rem_shift;
   logic [SB:0]          rem_diff;
   logic                 fits;
   logic [DB-1:0]        quo_next;
   logic [AB-1:0]        inc_mag;
   logic [CB-1:0]        chan_mag;
   logic signed [AB:0]   sum_wide;
   logic signed [AB-1:0] acc_sat;
   logic [AB-1:0]        rounded;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DB-1]};
      rem_diff  = rem_shift - {1'b0, span};
      fits      = rem_shift >= {1'b0, span};
      quo_next  = {quo_ff[DB-2:0], fits};
      inc_mag   = {{(AB-DB){1'b0}}, quo_next};
   end

   // saturating step add and round half up
   always_comb begin
      sum_wide = {acc_ff[AB-1], acc_ff} + {inc_ff[AB-1], inc_ff};
      if (sum_wide[AB] != sum_wide[AB-1]) begin
         acc_sat = sum_wide[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
      end else begin
         acc_sat = sum_wide[AB-1:0];
      end
      rounded = unsigned'(acc_sat) + (AB'(1) << (FB - 1));
      if (acc_sat[AB-1]) begin
         chan_out = '0;
      end else if (|rounded[AB-1:FB+CB]) begin
         chan_out = '1;
      end else begin
         chan_out = rounded[FB+CB-1:FB];
      end
   end

   always_comb begin
      chan_mag = (end_chan < start_chan) ? (start_chan - end_chan) : (end_chan - start_chan);
      acc_in   = acc_ff;
      inc_in   = inc_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      if (ctrl.load) begin
         acc_in = {{(AB-CB-FB){1'b0}}, start_chan, {FB{1'b0}}};
         quo_in = {chan_mag, {FB{1'b0}}};
         rem_in = '0;
         neg_in = end_chan < start_chan;
      end else if (ctrl.step) begin
         acc_in = acc_sat;
      end
      if (ctrl.div_shift) begin
         quo_in = quo_next;
         rem_in = fits ? rem_diff[SB-1:0] : rem_shift[SB-1:0];
      end
      if (ctrl.div_last) begin
         if (span == '0) begin
            inc_in = '0;
         end else if (neg_ff) begin
            inc_in = -signed'(inc_mag);
         end else begin
            inc_in = signed'(inc_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         inc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         inc_ff <= inc_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lcgs_merge.sv =====
`default_nettype none

module lcgs_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   capture,
   input  wire lcgs_pkg::chan_vec_type chans,
   output logic                        out_free,
   lcgs_rsp_if.source                  rsp_ch
);

   logic                            valid_ff, valid_in;
   logic [lcgs_pkg::PIXEL_BITS-1:0] color_ff, color_in;

   always_comb begin
      out_free = !valid_ff || rsp_ch.ready;
      valid_in = valid_ff;
      color_in = color_ff;
      if (capture) begin
         valid_in = 1'b1;
         // lane 0 is red, lane 2 is blue
         for (int l = 0; l < lcgs_pkg::NUM_LANES; l++) begin
            color_in[(lcgs_pkg::NUM_LANES-1-l)*lcgs_pkg::CHAN_BITS +: lcgs_pkg::CHAN_BITS] =
               chans[l];
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.pixel_color = color_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/line_color_gradient_stepper_core.sv =====
`default_nettype none

// Color gradient stepper: a load beat (mode 0) latches the start color and
// works out per-channel increments of (end - start) / max(|dx|, |dy|) in signed
// Q9.16, using three channel lanes side by side, each with its own restoring
// divider that retires one quotient bit per cycle. A load therefore keeps
// req_ready low after it is accepted until all FRAC_BITS + 8 quotient bits
// are retired. A step beat (mode 1) has the lanes add their increments with
// saturation and round, and the 24-bit RGB result is registered and shown
// on rsp the next cycle. Steps stream at one per cycle as long as rsp_ready
// keeps the output register draining. Alpha is dropped.
module line_color_gradient_stepper_core (
   input  wire logic  clock,
   input  wire logic  reset,
   lcgs_req_if.sink   req_ch,
   lcgs_rsp_if.source rsp_ch
);

   localparam int CW = lcgs_pkg::CHAN_BITS;
   localparam int NL = lcgs_pkg::NUM_LANES;

   lcgs_pkg::state_type              state_ff, state_in;
   logic [lcgs_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [lcgs_pkg::SPAN_BITS-1:0]   span_ff, span_in;
   lcgs_pkg::lane_ctrl_type          ctrl;
   lcgs_pkg::chan_vec_type           chans;
   logic                             accept;
   logic                             is_step;
   logic                             div_end;
   logic                             out_free;
   logic [lcgs_pkg::SPAN_BITS-1:0]   span_x;
   logic [lcgs_pkg::SPAN_BITS-1:0]   span_y;

   assign accept  = req_ch.valid && req_ch.ready;
   assign is_step = req_ch.mode == lcgs_pkg::MODE_STEP;
   assign div_end = cnt_ff == lcgs_pkg::CNT_BITS'(lcgs_pkg::DIV_BITS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcgs_pkg::ST_IDLE: begin
            if (accept && !is_step) begin
               state_in = lcgs_pkg::ST_DIVIDE;
            end
         end
         lcgs_pkg::ST_DIVIDE: begin
            if (div_end) begin
               state_in = lcgs_pkg::ST_IDLE;
            end
         end
         default: state_in = lcgs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready   = (state_ff == lcgs_pkg::ST_IDLE) && out_free;
      ctrl.load      = accept && !is_step;
      ctrl.step      = accept && is_step;
      ctrl.div_shift = state_ff == lcgs_pkg::ST_DIVIDE;
      ctrl.div_last  = (state_ff == lcgs_pkg::ST_DIVIDE) && div_end;
   end

   always_comb begin
      span_x  = lcgs_pkg::span_of(req_ch.delta_x);
      span_y  = lcgs_pkg::span_of(req_ch.delta_y);
      span_in = ctrl.load ? ((span_x > span_y) ? span_x : span_y) : span_ff;
      cnt_in  = (ctrl.div_shift && !div_end) ? cnt_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcgs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   for (genvar l = 0; l < NL; l++) begin : g_lane
      lcgs_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .start_chan (req_ch.start_color[(NL-1-l)*CW +: CW]),
         .end_chan   (req_ch.end_color[(NL-1-l)*CW +: CW]),
         .span       (span_ff),
         .chan_out   (chans[l])
      );
   end

   lcgs_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .capture  (ctrl.step),
      .chans    (chans),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lcgs_check.sv =====
`default_nettype none

module lcgs_check (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            req_mode,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [lcgs_pkg::PIXEL_BITS-1:0] rsp_pixel_color
);

   logic load_beat;
   logic step_beat;

   assign load_beat = req_valid && req_ready && (req_mode == lcgs_pkg::MODE_LOAD);
   assign step_beat = req_valid && req_ready && (req_mode == lcgs_pkg::MODE_STEP);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color))
      else $error("rsp beat changed while stalled");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step_beat |=> rsp_valid)
      else $error("step beat gave no result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_beat))
      else $error("result without a step beat");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load_beat |-> ##(lcgs_pkg::DIV_BITS) !req_ready)
      else $error("req taken while divider busy");

endmodule

bind line_color_gradient_stepper_core lcgs_check u_lcgs_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_mode        (req_ch.mode),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_color (rsp_ch.pixel_color)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
   import lcgs_pkg::*;

   localparam int RANDOM_BEATS  = 480;
   localparam int QUIET_BEATS   = 100;
   localparam int HOLD_CYCLES   = 120;
   localparam int PRESSURE_RUN  = 40;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 2000;

   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic [COLOR_BITS-1:0]        argb_type;
   typedef logic [PIXEL_BITS-1:0]        pixel_type;

   typedef struct packed {
      mode_type  mode;
      argb_type  start_argb;
      argb_type  end_argb;
      delta_type dx;
      delta_type dy;
      logic      known;
      pixel_type color;
   } beat_row_type;

   localparam int NUM_ROWS = 25;

   // known colors only where the arithmetic is obvious
   localparam beat_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{MODE_STEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 13'(-1), 13'(-1), 1'b1, 24'h000000},
      '{MODE_LOAD, 32'h00FF8001, 32'hFF00FFFF, 13'(1), 13'(0), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'h00FFFF},
      '{MODE_STEP, 32'hA5A5A5A5, 32'h5A5A5A5A, 13'(7), 13'(-7), 1'b1, 24'h00FFFF},
      '{MODE_STEP, 32'h00000000, 32'hFFFFFFFF, 13'(0), 13'(0), 1'b1, 24'h00FFFF},
      '{MODE_STEP, 32'hFFFFFFFF, 32'h00000000, 13'(-4096), 13'(4095), 1'b1, 24'h00FFFF},
      '{MODE_LOAD, 32'h12345678, 32'hAB345678, 13'(5), 13'(-7), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'h345678},
      '{MODE_LOAD, 32'h00102030, 32'hFFF0E0D0, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_STEP, 32'hDEADBEEF, 32'hCAFEF00D, 13'(4095), 13'(-4096), 1'b1, 24'h102030},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'h102030},
      '{MODE_LOAD, 32'h00000000, 32'h00010101, 13'(0), 13'(2), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'h010101},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'h010101},
      '{MODE_LOAD, 32'hFFFFFFFF, 32'h00000000, 13'(-4096), 13'(4095), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_LOAD, 32'h0080FF00, 32'h00FF0080, 13'(4095), 13'(-4095), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_LOAD, 32'h00010203, 32'h00000000, 13'(-3), 13'(1), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b0, 24'h0},
      '{MODE_LOAD, 32'h00000000, 32'h00FFFFFF, 13'(0), 13'(-1), 1'b0, 24'h0},
      '{MODE_STEP, 32'h00000000, 32'h00000000, 13'(0), 13'(0), 1'b1, 24'hFFFFFF}
   };

   logic clock;
   logic reset;

   lcgs_req_if req_ch ();
   lcgs_rsp_if rsp_ch ();

   line_color_gradient_stepper_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // expected color riding along with the beat on the directed rows
   logic      beat_known;
   pixel_type beat_color;

   bit quiet_tail;
   bit hold_request;

   acc_type   lane_acc [NUM_LANES];
   acc_type   lane_inc [NUM_LANES];
   pixel_type pending_colors [$];

   int error_count;
   int load_count;
   int step_count;
   int compare_count;

   always #5 clock = ~clock;

   function automatic int clipped_extent(input delta_type d);
      int mag;
      mag = (d < 0) ? -int'(d) : int'(d);
      return (mag > SPAN_MAX) ? SPAN_MAX : mag;
   endfunction

   function automatic void latch_gradient(input argb_type start_argb, input argb_type end_argb,
                                          input delta_type dx, input delta_type dy);
      int     span;
      int     first;
      int     last;
      int     diff;
      longint quot;
      span = clipped_extent(dx);
      if (clipped_extent(dy) > span) begin
         span = clipped_extent(dy);
      end
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         first = int'(start_argb[16 - 8 * lane +: 8]);
         last  = int'(end_argb[16 - 8 * lane +: 8]);
         diff  = last - first;
         lane_acc[lane] = ACC_BITS'(longint'(first) <<< FRAC_BITS);
         if (span == 0 || diff == 0) begin
            lane_inc[lane] = '0;
         end else begin
            quot = (longint'(diff < 0 ? -diff : diff) <<< FRAC_BITS) / span;
            lane_inc[lane] = ACC_BITS'(diff < 0 ? -quot : quot);
         end
      end
   endfunction

   function automatic pixel_type advance_gradient();
      longint    acc_max;
      longint    sum;
      longint    level;
      pixel_type color;
      acc_max = (longint'(1) <<< (ACC_BITS - 1)) - 1;
      color   = '0;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         sum = longint'(lane_acc[lane]) + longint'(lane_inc[lane]);
         if (sum > acc_max) begin
            sum = acc_max;
         end else if (sum < -acc_max - 1) begin
            sum = -acc_max - 1;
         end
         lane_acc[lane] = ACC_BITS'(sum);
         // round half away from zero, clamp to a byte
         if (sum < 0) begin
            level = 0;
         end else begin
            level = (sum + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (level > 255) begin
               level = 255;
            end
         end
         color[16 - 8 * lane +: 8] = 8'(level);
      end
      return color;
   endfunction

   function automatic argb_type random_argb();
      argb_type c;
      c = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         for (int lane = 0; lane < NUM_LANES; lane++) begin
            c[8 * lane +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
      end
      return c;
   endfunction

   function automatic delta_type random_delta();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 13'(-4096);
               1: return 13'(-4095);
               2: return 13'(4095);
               default: return 13'(0);
            endcase
         end
         1, 2: return 13'($urandom);
         default: return 13'(int'($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   task automatic send_beat(input mode_type mode, input argb_type start_argb,
                            input argb_type end_argb, input delta_type dx, input delta_type dy,
                            input logic known, input pixel_type color, input bit allow_gap);
      if (allow_gap && !quiet_tail && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.start_color <= start_argb;
      req_ch.end_color   <= end_argb;
      req_ch.delta_x     <= dx;
      req_ch.delta_y     <= dy;
      beat_known         <= known;
      beat_color         <= color;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // prediction on accepted input beats, checking on accepted output beats
   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_LOAD) begin
               latch_gradient(req_ch.start_color, req_ch.end_color,
                              req_ch.delta_x, req_ch.delta_y);
               load_count++;
            end else begin
               want = advance_gradient();
               if (beat_known) begin
                  want = beat_color;
               end
               pending_colors.push_back(want);
               step_count++;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_colors.size() == 0) begin
               error_count++;
               $display("%0t: unexpected pixel_color beat %06h", $time, rsp_ch.pixel_color);
            end else begin
               want = pending_colors.pop_front();
               compare_count++;
               if (rsp_ch.pixel_color !== want) begin
                  error_count++;
                  $display("%0t: pixel_color mismatch, expected %06h actual %06h",
                           $time, want, rsp_ch.pixel_color);
               end
            end
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int        random_beats;
      int        kind;
      int        span;
      int        steps;
      argb_type  start_argb;
      argb_type  end_argb;
      delta_type dx;
      delta_type dy;

      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_LOAD;
      req_ch.start_color = '0;
      req_ch.end_color   = '0;
      req_ch.delta_x     = '0;
      req_ch.delta_y     = '0;
      rsp_ch.ready       = 1'b0;
      beat_known         = 1'b0;
      beat_color         = '0;
      quiet_tail         = 1'b0;
      hold_request       = 1'b0;
      error_count        = 0;
      load_count         = 0;
      step_count         = 0;
      compare_count      = 0;
      random_beats       = 0;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         lane_acc[lane] = '0;
         lane_inc[lane] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < NUM_ROWS; row++) begin
         send_beat(DIRECTED_ROWS[row].mode, DIRECTED_ROWS[row].start_argb,
                   DIRECTED_ROWS[row].end_argb, DIRECTED_ROWS[row].dx, DIRECTED_ROWS[row].dy,
                   DIRECTED_ROWS[row].known, DIRECTED_ROWS[row].color, 1'b1);
      end

      // back-to-back steps into a stalled output so the input backs up
      hold_request = 1'b1;
      send_beat(MODE_LOAD, random_argb(), random_argb(), 13'(30), 13'(-12), 1'b0, '0, 1'b0);
      for (int k = 0; k < PRESSURE_RUN; k++) begin
         send_beat(MODE_STEP, $urandom, $urandom, random_delta(), random_delta(), 1'b0, '0,
                   1'b0);
      end

      while (random_beats < RANDOM_BEATS) begin
         quiet_tail = (random_beats >= RANDOM_BEATS - QUIET_BEATS);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // stray step with junk in the ignored fields
            send_beat(MODE_STEP, $urandom, $urandom, random_delta(), random_delta(), 1'b0, '0,
                      1'b1);
            random_beats++;
         end else begin
            start_argb = random_argb();
            end_argb   = ($urandom_range(0, 7) == 0) ?
                         {8'($urandom), start_argb[23:0]} : random_argb();
            dx = random_delta();
            dy = random_delta();
            send_beat(MODE_LOAD, start_argb, end_argb, dx, dy, 1'b0, '0, 1'b1);
            random_beats++;
            // a lone load leaves a broken sequence behind
            if (kind != 1) begin
               span = clipped_extent(dx);
               if (clipped_extent(dy) > span) begin
                  span = clipped_extent(dy);
               end
               steps = $urandom_range(1, (span + 3 > 24) ? 24 : span + 3);
               for (int k = 0; k < steps; k++) begin
                  send_beat(MODE_STEP, $urandom, $urandom, random_delta(), random_delta(),
                            1'b0, '0, 1'b1);
                  random_beats++;
               end
            end
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d gradient loads and %0d pixel steps, %0d colors compared",
               load_count, step_count, compare_count);
      $display("including span clipping, zero extents, equal colors and saturation");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
